// ===== hw/rtl/stld_pkg.sv =====
// Shared types and constants for the Student-t latent derivative block.
// Holds the request and response words, the opcode, status and register codes.
// No dependencies.
`default_nettype none

package stld_pkg;

   // fixed field widths
   localparam int DATA_W        = 32;
   localparam int CFG_W         = 24;
   localparam int FRAC_BITS_DEF = 16;

   // register reset values: df = 3.0, sigma = 1.0
   localparam logic [CFG_W-1:0] DOF_RESET   = 24'd196608;
   localparam logic [CFG_W-1:0] NOISE_RESET = 24'd65536;

   typedef enum logic [1:0] {
      OP_INVALID = 2'd0,
      OP_FIRST   = 2'd1,
      OP_SECOND  = 2'd2,
      OP_THIRD   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_SAT     = 2'd2
   } status_type;

   typedef enum logic {
      CSR_DOF   = 1'b0,
      CSR_NOISE = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [DATA_W-1:0] label_value;
      logic signed [DATA_W-1:0] latent_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] derivative_value;
      status_type               status;
   } rsp_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/studentt_latent_derivatives.sv =====
// Top level of the Student-t latent derivative block.
// Depends on stld_pkg, stld_mul and stld_div.
//
// Usage: each request word carries a derivative order, a label y and a latent f
// (signed Q fixed point). One response word comes back per request with the
// first, second or third derivative of the Student-t log likelihood in f and
// a status (ok, invalid order, saturated). Words are taken when valid is high
// and stall is low. Write df and sigma through the csr channel while idle;
// csr_ready is always high.
// Throughput: one word per cycle while no response is stalled. Pipeline: one
// input stage, the stages of five chained multipliers (one slice of b per stage,
// slice = 1024 / a_width), DATA_W + 1 divider stages and one output register.
// The df*sigma^2 term follows a register write through the configuration
// registers and the free-running multipliers u_mul_ss and u_mul_s.
// Reset clears all valid bits and loads df = 3.0 and sigma = 1.0.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall rises; nothing is dropped or repeated.
`default_nettype none

module studentt_latent_derivatives
   import stld_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_word,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire csr_index_type     csr_index,
   input  wire logic [CFG_W-1:0]  csr_wdata
);

   localparam int W   = DATA_W;
   localparam int RW  = W + 1;
   localparam int R2W = 2 * RW + FRAC_BITS;
   localparam int SW  = 3 * CFG_W;
   localparam int AW  = max_int(R2W, SW) + 1;
   localparam int KW  = CFG_W + 1;
   localparam int T2W = max_int(R2W, SW);
   localparam int T3W = max_int(R2W, SW + 2);
   localparam int PKW = KW + T2W;
   localparam int PXW = PKW + T3W;
   localparam int NW  = PXW + 5 * FRAC_BITS + 1;
   localparam int DW  = 3 * AW;

   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      opcode_type    op;
      logic          rneg;
      logic [RW-1:0] rmag;
   } s0_type;

   typedef struct packed {
      opcode_type     op;
      logic           rneg;
      logic [RW-1:0]  rmag;
      logic [T2W-1:0] t2;
      logic           neg2;
      logic [T3W-1:0] t3;
      logic           neg3;
      logic           azero;
      logic [AW-1:0]  a;
   } sa_type;

   typedef struct packed {
      sa_type          sa;
      logic [2*AW-1:0] a2;
   } sm3_type;

   typedef struct packed {
      opcode_type     op;
      logic           neg;
      logic           azero;
      logic [DW-1:0]  d;
      logic [T3W-1:0] y;
   } sb_type;

   typedef struct packed {
      opcode_type    op;
      logic          neg;
      logic          azero;
      logic [DW-1:0] d;
   } sc_type;

   typedef struct packed {
      opcode_type op;
      logic       neg;
      logic       azero;
   } sd_type;

   logic             advance;
   logic [CFG_W-1:0] dof_ff, noise_ff;

   // hold the whole pipeline while a response waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dof_ff   <= DOF_RESET;
         noise_ff <= NOISE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DOF:   dof_ff   <= csr_wdata;
            CSR_NOISE: noise_ff <= csr_wdata;
         endcase
      end
   end

   // form df*sigma^2 and df+1 from the registers, free running
   logic [2*CFG_W-1:0] ss;
   logic [CFG_W-1:0]   dof1, dof2;
   logic [SW-1:0]      s_val;
   logic [KW-1:0]      k_val;

   stld_mul #(.AW(CFG_W), .BW(CFG_W), .SW(CFG_W)) u_mul_ss (
      .clock(clock), .reset(reset), .advance(1'b1), .vld_in(1'b1),
      .a_in(noise_ff), .b_in(noise_ff), .side_in(dof_ff),
      .vld_out(), .p_out(ss), .side_out(dof1)
   );

   stld_mul #(.AW(2*CFG_W), .BW(CFG_W), .SW(CFG_W)) u_mul_s (
      .clock(clock), .reset(reset), .advance(1'b1), .vld_in(1'b1),
      .a_in(ss), .b_in(dof1), .side_in(dof1),
      .vld_out(), .p_out(s_val), .side_out(dof2)
   );

   assign k_val = KW'(dof2) + (KW'(1) << FRAC_BITS);

   // input stage: residual sign and magnitude
   s0_type        st0_ff;
   logic          st0_vld_ff;
   logic [RW-1:0] r_diff;
   assign r_diff = RW'(signed'(req_word.label_value)) - RW'(signed'(req_word.latent_value));

   always_ff @(posedge clock) begin
      if (advance) begin
         st0_ff.op   <= req_word.opcode;
         st0_ff.rneg <= r_diff[RW-1];
         st0_ff.rmag <= r_diff[RW-1] ? (RW'(0) - r_diff) : r_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_vld_ff <= 1'b0;
      end else if (advance) begin
         st0_vld_ff <= req_valid;
      end
   end

   // r^2
   logic            m1_vld;
   logic [2*RW-1:0] m1_p;
   s0_type          m1_side;

   stld_mul #(.AW(RW), .BW(RW), .SW($bits(s0_type))) u_mul_r2 (
      .clock(clock), .reset(reset), .advance(advance), .vld_in(st0_vld_ff),
      .a_in(st0_ff.rmag), .b_in(st0_ff.rmag), .side_in(st0_ff),
      .vld_out(m1_vld), .p_out(m1_p), .side_out(m1_side)
   );

   // a = r2 + s and the two differences
   logic [R2W-1:0]  r2;
   logic [SW+1:0]   s3;
   logic            ge2, ge3;
   sa_type          sa;

   always_comb begin
      r2       = R2W'(m1_p) << FRAC_BITS;
      s3       = (SW+2)'(s_val) + ((SW+2)'(s_val) << 1);
      ge2      = T2W'(r2) >= T2W'(s_val);
      ge3      = T3W'(r2) >= T3W'(s3);
      sa.op    = m1_side.op;
      sa.rneg  = m1_side.rneg;
      sa.rmag  = m1_side.rmag;
      sa.t2    = ge2 ? (T2W'(r2) - T2W'(s_val)) : (T2W'(s_val) - T2W'(r2));
      sa.neg2  = !ge2;
      sa.t3    = ge3 ? (T3W'(r2) - T3W'(s3)) : (T3W'(s3) - T3W'(r2));
      sa.neg3  = (!ge3) ^ m1_side.rneg;
      sa.a     = AW'(r2) + AW'(s_val);
      sa.azero = (sa.a == '0);
   end

   // a^2
   logic            m2_vld;
   logic [2*AW-1:0] m2_p;
   sa_type          m2_side;
   sm3_type         sm3;

   stld_mul #(.AW(AW), .BW(AW), .SW($bits(sa_type))) u_mul_a2 (
      .clock(clock), .reset(reset), .advance(advance), .vld_in(m1_vld),
      .a_in(sa.a), .b_in(sa.a), .side_in(sa),
      .vld_out(m2_vld), .p_out(m2_p), .side_out(m2_side)
   );

   assign sm3.sa = m2_side;
   assign sm3.a2 = m2_p;

   // a^3
   logic            m3_vld;
   logic [3*AW-1:0] m3_p;
   sm3_type         m3_side;

   stld_mul #(.AW(2*AW), .BW(AW), .SW($bits(sm3_type))) u_mul_a3 (
      .clock(clock), .reset(reset), .advance(advance), .vld_in(m2_vld),
      .a_in(m2_p), .b_in(m2_side.a), .side_in(sm3),
      .vld_out(m3_vld), .p_out(m3_p), .side_out(m3_side)
   );

   // pick denominator, sign and numerator factors by order
   sb_type         sb;
   logic [T2W-1:0] x_val;

   always_comb begin
      sb.op    = m3_side.sa.op;
      sb.azero = m3_side.sa.azero;
      unique case (m3_side.sa.op)
         OP_FIRST: begin
            sb.d   = DW'(m3_side.sa.a);
            sb.neg = m3_side.sa.rneg;
            x_val  = T2W'(m3_side.sa.rmag);
            sb.y   = T3W'(1);
         end
         OP_SECOND: begin
            sb.d   = DW'(m3_side.a2);
            sb.neg = m3_side.sa.neg2;
            x_val  = m3_side.sa.t2;
            sb.y   = T3W'(1);
         end
         OP_THIRD: begin
            sb.d   = DW'(m3_p);
            sb.neg = m3_side.sa.neg3;
            x_val  = T2W'(m3_side.sa.rmag);
            sb.y   = m3_side.sa.t3;
         end
         OP_INVALID: begin
            sb.d   = DW'(m3_p);
            sb.neg = 1'b0;
            x_val  = '0;
            sb.y   = '0;
         end
      endcase
   end

   // (df+1) times r or the second order difference
   logic           m4_vld;
   logic [PKW-1:0] m4_p;
   sb_type         m4_side;
   sc_type         sc;

   stld_mul #(.AW(KW), .BW(T2W), .SW($bits(sb_type))) u_mul_k (
      .clock(clock), .reset(reset), .advance(advance), .vld_in(m3_vld),
      .a_in(k_val), .b_in(x_val), .side_in(sb),
      .vld_out(m4_vld), .p_out(m4_p), .side_out(m4_side)
   );

   assign sc.op    = m4_side.op;
   assign sc.neg   = m4_side.neg;
   assign sc.azero = m4_side.azero;
   assign sc.d     = m4_side.d;

   // times the third order difference, or one
   logic           m5_vld;
   logic [PXW-1:0] m5_p;
   sc_type         m5_side;

   stld_mul #(.AW(PKW), .BW(T3W), .SW($bits(sc_type))) u_mul_t (
      .clock(clock), .reset(reset), .advance(advance), .vld_in(m4_vld),
      .a_in(m4_p), .b_in(m4_side.y), .side_in(sc),
      .vld_out(m5_vld), .p_out(m5_p), .side_out(m5_side)
   );

   // align the numerator to the output fraction
   logic [NW-1:0] n_val;
   sd_type        sd;

   always_comb begin
      unique case (m5_side.op)
         OP_FIRST:   n_val = NW'(m5_p) << (2 * FRAC_BITS);
         OP_SECOND:  n_val = NW'(m5_p) << (3 * FRAC_BITS);
         OP_THIRD:   n_val = NW'(m5_p) << (5 * FRAC_BITS + 1);
         OP_INVALID: n_val = '0;
      endcase
      sd.op    = m5_side.op;
      sd.neg   = m5_side.neg;
      sd.azero = m5_side.azero;
   end

   logic         dv_vld;
   logic [W-1:0] dv_q;
   logic         dv_ovf;
   sd_type       dv_side;

   stld_div #(.NW(NW), .DW(DW), .QW(W), .SW($bits(sd_type))) u_div (
      .clock(clock), .reset(reset), .advance(advance), .vld_in(m5_vld),
      .n_in(n_val), .d_in(m5_side.d), .side_in(sd),
      .vld_out(dv_vld), .q_out(dv_q), .ovf_out(dv_ovf), .side_out(dv_side)
   );

   // saturate, apply sign and settle the special cases
   logic         big;
   logic [W-1:0] q_sat, q_signed;
   rsp_type      rsp_in;
   rsp_type      rsp_ff;
   logic         rsp_vld_ff;

   always_comb begin
      big      = dv_ovf || (dv_side.neg ? (dv_q > LIM_NEG) : (dv_q > LIM_POS));
      q_sat    = big ? (dv_side.neg ? LIM_NEG : LIM_POS) : dv_q;
      q_signed = dv_side.neg ? (W'(0) - q_sat) : q_sat;
      priority if (dv_side.op == OP_INVALID) begin
         rsp_in.derivative_value = '0;
         rsp_in.status           = ST_INVALID;
      end else if (dv_side.azero && dv_side.op == OP_SECOND) begin
         rsp_in.derivative_value = LIM_NEG;
         rsp_in.status           = ST_SAT;
      end else if (dv_side.azero) begin
         rsp_in.derivative_value = '0;
         rsp_in.status           = ST_OK;
      end else begin
         rsp_in.derivative_value = q_signed;
         rsp_in.status           = big ? ST_SAT : ST_OK;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= dv_vld;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

   logic [W-1:0] rsp_bits;
   assign rsp_bits = rsp_ff.derivative_value;

   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ff.status == ST_INVALID |-> rsp_bits == '0)
      else $error("invalid order must return zero");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ff.status == ST_SAT |-> rsp_bits == LIM_POS || rsp_bits == LIM_NEG)
      else $error("saturated result off the range limits");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(st0_ff) && $stable(st0_vld_ff))
      else $error("input stage moved while the pipeline was held");

endmodule

`default_nettype wire

// ===== hw/rtl/stld_mul.sv =====
// Pipelined unsigned multiplier: one slice of the b operand per stage.
// Carries a side word and a valid bit in step with the product. No dependencies.
`default_nettype none

module stld_mul #(
   parameter int AW = 32,
   parameter int BW = 32,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          vld_in,
   input  wire logic [AW-1:0] a_in,
   input  wire logic [BW-1:0] b_in,
   input  wire logic [SW-1:0] side_in,
   output logic               vld_out,
   output logic [AW+BW-1:0]   p_out,
   output logic [SW-1:0]      side_out
);

   // slice width keeps each partial product near 32x32
   localparam int CHUNK_RAW = 1024 / AW;
   localparam int CHUNK     = (CHUNK_RAW < 1) ? 1 : ((CHUNK_RAW > BW) ? BW : CHUNK_RAW);
   localparam int NSTG      = (BW + CHUNK - 1) / CHUNK;
   localparam int BPW       = NSTG * CHUNK;
   localparam int PW        = AW + BPW;

   logic [AW-1:0]  a_ff    [NSTG];
   logic [BPW-1:0] b_ff    [NSTG];
   logic [PW-1:0]  acc_ff  [NSTG];
   logic [SW-1:0]  side_ff [NSTG];
   logic           vld_ff  [NSTG];

   for (genvar i = 0; i < NSTG; i++) begin : g_stg
      logic [AW-1:0]       a_src;
      logic [BPW-1:0]      b_src;
      logic [PW-1:0]       acc_src;
      logic [SW-1:0]       side_src;
      logic                vld_src;
      logic [AW+CHUNK-1:0] pp;

      if (i == 0) begin : g_first
         assign a_src    = a_in;
         assign b_src    = BPW'(b_in);
         assign acc_src  = '0;
         assign side_src = side_in;
         assign vld_src  = vld_in;
      end else begin : g_next
         assign a_src    = a_ff[i-1];
         assign b_src    = b_ff[i-1];
         assign acc_src  = acc_ff[i-1];
         assign side_src = side_ff[i-1];
         assign vld_src  = vld_ff[i-1];
      end

      // partial product of this slice
      assign pp = (AW+CHUNK)'(a_src) * (AW+CHUNK)'(b_src[i*CHUNK +: CHUNK]);

      // accumulate and pass operands on
      always_ff @(posedge clock) begin
         if (advance) begin
            a_ff[i]    <= a_src;
            b_ff[i]    <= b_src;
            side_ff[i] <= side_src;
            acc_ff[i]  <= acc_src + (PW'(pp) << (i * CHUNK));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_src;
         end
      end
   end

   assign p_out    = acc_ff[NSTG-1][AW+BW-1:0];
   assign side_out = side_ff[NSTG-1];
   assign vld_out  = vld_ff[NSTG-1];

endmodule

`default_nettype wire

// ===== hw/rtl/stld_div.sv =====
// Pipelined restoring divider: an overflow check, then one quotient bit per stage.
// Carries a side word and a valid bit in step. No dependencies.
`default_nettype none

module stld_div #(
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int QW = 32,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          vld_in,
   input  wire logic [NW-1:0] n_in,
   input  wire logic [DW-1:0] d_in,
   input  wire logic [SW-1:0] side_in,
   output logic               vld_out,
   output logic [QW-1:0]      q_out,
   output logic               ovf_out,
   output logic [SW-1:0]      side_out
);

   localparam int XW = (NW > DW + QW) ? NW : DW + QW;

   logic [XW-1:0] rem_ff  [QW+1];
   logic [DW-1:0] d_ff    [QW+1];
   logic [QW-1:0] q_ff    [QW+1];
   logic          ovf_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];
   logic          vld_ff  [QW+1];

   for (genvar k = 0; k <= QW; k++) begin : g_stg
      if (k == 0) begin : g_first
         // flag a quotient too wide for QW bits
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k]  <= XW'(n_in);
               d_ff[k]    <= d_in;
               q_ff[k]    <= '0;
               ovf_ff[k]  <= XW'(n_in) >= (XW'(d_in) << QW);
               side_ff[k] <= side_in;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (advance) begin
               vld_ff[k] <= vld_in;
            end
         end
      end else begin : g_bit
         logic [XW-1:0] dsh;
         logic          take;
         assign dsh  = XW'(d_ff[k-1]) << (QW - k);
         assign take = rem_ff[k-1] >= dsh;

         // subtract the shifted divisor where it fits
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k]  <= take ? (rem_ff[k-1] - dsh) : rem_ff[k-1];
               d_ff[k]    <= d_ff[k-1];
               q_ff[k]    <= q_ff[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
               ovf_ff[k]  <= ovf_ff[k-1];
               side_ff[k] <= side_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (advance) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign vld_out  = vld_ff[QW];
   assign q_out    = q_ff[QW];
   assign ovf_out  = ovf_ff[QW];
   assign side_out = side_ff[QW];

endmodule

`default_nettype wire
